FILE: hdl/uer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, register codes, reset values and beat types of the
// ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TRIG_W      = 8;
	localparam int HOLD_W      = 20;
	localparam int DIST_W      = 11;
	localparam int DIGIT_W     = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE_CM = 2'd2;

	localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd21;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 20'd80000;
	localparam logic [DIST_W-1:0] MAXD_RESET = 11'd700;

	// floor(count*17/1000) == (count * 17*ceil(2^35/1000)) >> 35 over the count range
	localparam int DIV_SHIFT = 35;
	localparam int RECIP_W   = 30;
	localparam logic [RECIP_W-1:0] DIST_RECIP = 30'd584115563;
	localparam int PROD_W = COUNT_WIDTH + RECIP_W;
	localparam int RAW_W  = PROD_W - DIV_SHIFT;
	localparam int CMP_W  = (RAW_W > DIST_W) ? RAW_W : DIST_W;
	localparam logic [CMP_W-1:0] DIST_SAT = CMP_W'((1 << DIST_W) - 1);

	typedef struct packed {
		logic                   trig;
		logic                   done;
		logic                   ovf;
		logic [COUNT_WIDTH-1:0] count;
	} meas_t;

endpackage
`default_nettype wire

FILE: hdl/uer_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_fsm
// Phase controller: trigger pulse, echo wait, echo-high count, holdoff.
// Advances one tick per accepted beat and reports that tick's measurement.
// ----------------------------------------------------------------------------
module uer_fsm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       echo,
	input  wire logic [uer_pkg::TRIG_W-1:0] trigger_ticks,
	input  wire logic [uer_pkg::HOLD_W-1:0] holdoff_ticks,
	output uer_pkg::meas_t                  meas
);
	import uer_pkg::*;

	typedef enum logic [3:0] {
		PH_TRIGGER = 4'b0001,
		PH_WAIT    = 4'b0010,
		PH_COUNT   = 4'b0100,
		PH_HOLDOFF = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [HOLD_W-1:0]      ticks_q, ticks_d, ticks_inc;
	logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
	logic                   ovf_q, ovf_d;
	logic [TRIG_W-1:0]      trig_len;

	assign ticks_inc = ticks_q + 1'b1;
	assign count_inc = count_q + 1'b1;
	// a zero length still gives a one-tick pulse
	assign trig_len  = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;

	always_comb begin
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		count_d    = count_q;
		ovf_d      = ovf_q;
		meas       = '0;
		meas.count = count_q;
		meas.ovf   = ovf_q;
		case (phase_q)
			PH_TRIGGER: begin
				meas.trig = 1'b1;
				if (ticks_inc >= {{(HOLD_W-TRIG_W){1'b0}}, trig_len}) begin
					phase_d = PH_WAIT;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					phase_d = PH_COUNT;
					count_d = COUNT_WIDTH'(1);
					ovf_d   = 1'b0;
				end
			end
			PH_COUNT: begin
				if (echo) begin
					count_d = count_inc;
					if (count_inc == '0) begin
						ovf_d = 1'b1;
					end
				end else begin
					meas.done = 1'b1;
					ovf_d     = 1'b0;
					ticks_d   = '0;
					phase_d   = (holdoff_ticks == '0) ? PH_TRIGGER : PH_HOLDOFF;
				end
			end
			PH_HOLDOFF: begin
				if (ticks_inc >= holdoff_ticks) begin
					phase_d = PH_TRIGGER;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			default: begin
				phase_d = PH_TRIGGER;
				ticks_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIGGER;
			ticks_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ultrasonic_echo_ranger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo pulse-width rangefinder: one input beat per timer tick, one result
// beat per tick with trigger level, done flag, distance and digits.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick carrying the echo level; each yields one
// output beat. The block accepts one beat every cycle while the output does
// not stall. A result passes five register stages: the phase controller, the
// reciprocal multiply for count*17/1000, range check and mod-1000 fold,
// hundreds digit, tens and units digits. Output stalls back up stage by stage,
// so empty stages still take input while a result waits. The user must write
// registers through cfg_we/cfg_index/cfg_wdata only while idle; no guard.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [uer_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] echo
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [0] trigger, [1] done_res, [2] out_of_range, [13:3] distance_cm,
	// [17:14] digit_metres, [21:18] digit_decimetres, [25:22] digit_centimetres
	output logic [uer_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import uer_pkg::*;

	localparam int R_W   = 10;
	localparam int REM_W = 7;

	logic [TRIG_W-1:0] trigger_ticks_q;
	logic [HOLD_W-1:0] holdoff_ticks_q;
	logic [DIST_W-1:0] max_distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIG_RESET;
			holdoff_ticks_q <= HOLD_RESET;
			max_distance_q  <= MAXD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER_TICKS:   trigger_ticks_q <= cfg_wdata[TRIG_W-1:0];
				REG_HOLDOFF_TICKS:   holdoff_ticks_q <= cfg_wdata[HOLD_W-1:0];
				REG_MAX_DISTANCE_CM: max_distance_q  <= cfg_wdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake: a stage loads when empty or when the next one moves
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	assign rdy5          = !v5_q || m_axis_tready;
	assign rdy4          = !v4_q || rdy5;
	assign rdy3          = !v3_q || rdy4;
	assign rdy2          = !v2_q || rdy3;
	assign rdy1          = !v1_q || rdy2;
	assign s_axis_tready = rdy1;
	assign accept        = s_axis_tvalid && rdy1;
	assign m_axis_tvalid = v5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_axis_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
		end
	end

	// stage 1: phase controller
	meas_t meas, meas_s1;

	uer_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.echo          (s_axis_tdata[0]),
		.trigger_ticks (trigger_ticks_q),
		.holdoff_ticks (holdoff_ticks_q),
		.meas          (meas)
	);

	always_ff @(posedge clk) begin
		if (accept) meas_s1 <= meas;
	end

	// stage 2: reciprocal multiply
	logic              trig_s2, done_s2, ovf_s2;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v1_q) begin
			trig_s2 <= meas_s1.trig;
			done_s2 <= meas_s1.done;
			ovf_s2  <= meas_s1.ovf;
			prod_s2 <= {{RECIP_W{1'b0}}, meas_s1.count} *
			           {{COUNT_WIDTH{1'b0}}, DIST_RECIP};
		end
	end

	// stage 3: saturate, range check, fold modulo 1000
	logic [CMP_W-1:0]  raw_ext, max_ext;
	logic [DIST_W-1:0] dist_c;
	logic [R_W-1:0]    r_c;
	logic              oor_c;
	logic              trig_s3, done_s3, oor_s3;
	logic [DIST_W-1:0] dist_s3;
	logic [R_W-1:0]    r_s3;

	assign raw_ext = CMP_W'(prod_s2[PROD_W-1:DIV_SHIFT]);
	assign max_ext = CMP_W'(max_distance_q);
	assign dist_c  = (raw_ext > DIST_SAT) ? DIST_SAT[DIST_W-1:0] : raw_ext[DIST_W-1:0];
	assign oor_c   = ovf_s2 || (raw_ext >= max_ext);

	always_comb begin
		if (dist_c >= DIST_W'(2000)) begin
			r_c = R_W'(dist_c - DIST_W'(2000));
		end else if (dist_c >= DIST_W'(1000)) begin
			r_c = R_W'(dist_c - DIST_W'(1000));
		end else begin
			r_c = R_W'(dist_c);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_q) begin
			trig_s3 <= trig_s2;
			done_s3 <= done_s2;
			oor_s3  <= done_s2 && oor_c;
			dist_s3 <= done_s2 ? dist_c : '0;
			// no digits unless a valid in-range result
			r_s3    <= (done_s2 && !oor_c) ? r_c : '0;
		end
	end

	// stage 4: hundreds digit, x/100 == (x*41)>>12 for x < 1000
	logic [15:0]        mul41;
	logic [DIGIT_W-1:0] dm_c;
	logic [10:0]        rem100;
	logic               trig_s4, done_s4, oor_s4;
	logic [DIST_W-1:0]  dist_s4;
	logic [DIGIT_W-1:0] dm_s4;
	logic [REM_W-1:0]   rem_s4;

	assign mul41  = 16'(r_s3) * 16'd41;
	assign dm_c   = mul41[15:12];
	assign rem100 = 11'(r_s3) - 11'(dm_c) * 11'd100;

	always_ff @(posedge clk) begin
		if (rdy4 && v3_q) begin
			trig_s4 <= trig_s3;
			done_s4 <= done_s3;
			oor_s4  <= oor_s3;
			dist_s4 <= dist_s3;
			dm_s4   <= dm_c;
			rem_s4  <= rem100[REM_W-1:0];
		end
	end

	// stage 5: tens and units, x/10 == (x*205)>>11 for x < 100
	logic [14:0]        mul205;
	logic [DIGIT_W-1:0] dd_c;
	logic [7:0]         units;
	logic               trig_s5, done_s5, oor_s5;
	logic [DIST_W-1:0]  dist_s5;
	logic [DIGIT_W-1:0] dm_s5, dd_s5, dc_s5;

	assign mul205 = 15'(rem_s4) * 15'd205;
	assign dd_c   = mul205[14:11];
	assign units  = 8'(rem_s4) - 8'(dd_c) * 8'd10;

	always_ff @(posedge clk) begin
		if (rdy5 && v4_q) begin
			trig_s5 <= trig_s4;
			done_s5 <= done_s4;
			oor_s5  <= oor_s4;
			dist_s5 <= dist_s4;
			dm_s5   <= dm_s4;
			dd_s5   <= dd_c;
			dc_s5   <= units[DIGIT_W-1:0];
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W - 3 - DIST_W - 3*DIGIT_W){1'b0}},
	                       dc_s5, dd_s5, dm_s5, dist_s5, oor_s5, done_s5, trig_s5};

endmodule
`default_nettype wire

FILE: dv/ultrasonic_echo_ranger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test
// Streams echo ticks into the ranger while both sides idle at random. A tick
// level model of the phase machine predicts every result beat, which is
// compared field by field. Covers reset values, zero trigger, holdoff and
// limit, register writes mid-phase and random pulses.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_test;
	import uer_pkg::*;

	localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {TRIGGER_PULSE, ECHO_WAIT, ECHO_COUNT, HOLDOFF} ranger_phase_e;
	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_PERIODIC, RX_BLOCK} rx_mode_e;

	typedef struct packed {
		logic               trig;
		logic               done;
		logic               oor;
		logic [DIST_W-1:0]  dist_cm;
		logic [DIGIT_W-1:0] metres;
		logic [DIGIT_W-1:0] decim;
		logic [DIGIT_W-1:0] centim;
	} tick_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [0] echo
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [0] trigger, [1] done_res, [2] out_of_range, [13:3] distance_cm,
	// [17:14] digit_metres, [21:18] digit_decimetres, [25:22] digit_centimetres
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

	// model of the ranger
	ranger_phase_e          phase_q     = TRIGGER_PULSE;
	logic [HOLD_W-1:0]      tick_cnt    = '0;
	logic [COUNT_WIDTH-1:0] echo_ticks  = '0;
	logic                   wrapped     = 1'b0;
	logic [TRIG_W-1:0]      trig_len    = TRIG_RESET;
	logic [HOLD_W-1:0]      holdoff_len = HOLD_RESET;
	logic [DIST_W-1:0]      range_limit = MAXD_RESET;

	tick_result_t pending_ticks[$];
	int unsigned  ticks_sent    = 0;
	int unsigned  readings_seen = 0;
	int unsigned  mismatches    = 0;
	int unsigned  cycle_count   = 0;
	int unsigned  burst_left    = 0;
	bit           tx_bursty     = 1'b1;
	bit           rx_stalls     = 1'b1;
	int unsigned  rx_window     = 0;
	int unsigned  rx_step       = 0;
	rx_mode_e     rx_mode       = RX_STREAM;

	ultrasonic_echo_ranger dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// advance the model by one tick
	task automatic step_ranger(input logic echo_lvl, output tick_result_t r);
		int unsigned raw;
		int unsigned rem;
		r = '0;
		case (phase_q)
			TRIGGER_PULSE: begin
				r.trig = 1'b1;
				tick_cnt = tick_cnt + 1'b1;
				// count is already 1 here, so a zero length acts as one
				if (tick_cnt >= trig_len) begin
					phase_q = ECHO_WAIT;
					tick_cnt = '0;
				end
			end
			ECHO_WAIT: begin
				if (echo_lvl) begin
					phase_q = ECHO_COUNT;
					echo_ticks = COUNT_WIDTH'(1);
					wrapped = 1'b0;
				end
			end
			ECHO_COUNT: begin
				if (echo_lvl) begin
					echo_ticks = echo_ticks + 1'b1;
					if (echo_ticks == 0)
						wrapped = 1'b1;
				end else begin
					raw = 32'(echo_ticks) * 17 / 1000;
					r.done = 1'b1;
					r.dist_cm = (raw > 2047) ? '1 : raw[DIST_W-1:0];
					r.oor = wrapped || (raw >= range_limit);
					if (!r.oor) begin
						rem = r.dist_cm % 1000;
						r.metres = DIGIT_W'(rem / 100);
						r.decim  = DIGIT_W'((rem % 100) / 10);
						r.centim = DIGIT_W'(rem % 10);
					end
					wrapped = 1'b0;
					tick_cnt = '0;
					phase_q = (holdoff_len == 0) ? TRIGGER_PULSE : HOLDOFF;
				end
			end
			default: begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= holdoff_len) begin
					phase_q = TRIGGER_PULSE;
					tick_cnt = '0;
				end
			end
		endcase
	endtask

	task automatic send_tick(input logic echo_lvl);
		tick_result_t r;
		int unsigned gap;
		if (tx_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(echo_lvl);
		do @(posedge clk); while (!s_axis_tready);
		step_ranger(echo_lvl, r);
		pending_ticks.push_back(r);
		ticks_sent++;
		if (r.done)
			readings_seen++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// only while idle; model follows the write at the same edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_TRIGGER_TICKS:   trig_len    = val[TRIG_W-1:0];
			REG_HOLDOFF_TICKS:   holdoff_len = val[HOLD_W-1:0];
			REG_MAX_DISTANCE_CM: range_limit = val[DIST_W-1:0];
			default: ;  // unused index does nothing
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// noise until the ranger waits, then a clean low/high/low echo
	task automatic run_echo_pulse(input int unsigned lo, input int unsigned hi);
		while (phase_q != ECHO_WAIT)
			send_tick(1'($urandom_range(0, 1)));
		repeat (lo) send_tick(1'b0);
		repeat (hi) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ticks.size() == 0) begin
				$error("result beat with no tick pending: %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_ticks.pop_front();
				check_field("trigger", want.trig, m_axis_tdata[0]);
				check_field("done_res", want.done, m_axis_tdata[1]);
				check_field("out_of_range", want.oor, m_axis_tdata[2]);
				check_field("distance_cm", want.dist_cm, m_axis_tdata[13:3]);
				check_field("digit_metres", want.metres, m_axis_tdata[17:14]);
				check_field("digit_decimetres", want.decim, m_axis_tdata[21:18]);
				check_field("digit_centimetres", want.centim, m_axis_tdata[25:22]);
			end
		end
	end

	always @(posedge clk) begin
		if (rx_window == 0) begin
			rx_window = $urandom_range(16, 80);
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		end
		rx_window--;
		rx_step++;
		if (!rx_stalls)
			m_axis_tready <= 1'b1;
		else case (rx_mode)
			RX_STREAM:   m_axis_tready <= 1'b1;
			RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_axis_tready <= (rx_step % 3) != 0;
			default:     m_axis_tready <= rx_window > 12;
		endcase
	end

	// reset trigger length: echo during the pulse is ignored
	task automatic test_reset_values();
		repeat (TRIG_RESET) send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		settle();
	endtask

	task automatic test_edge_cases();
		write_reg(REG_TRIGGER_TICKS, '0);
		write_reg(REG_HOLDOFF_TICKS, '0);
		write_reg(REG_MAX_DISTANCE_CM, '0);
		write_reg(REG_UNUSED, '1);
		run_echo_pulse(2, 1);
		run_echo_pulse(0, 1);
		settle();
		write_reg(REG_MAX_DISTANCE_CM, CFG_DATA_W'(1));
		run_echo_pulse(1, 59);  // 1 cm, at the limit
		run_echo_pulse(0, 58);  // 0 cm
		settle();
		write_reg(REG_MAX_DISTANCE_CM, '1);
		run_echo_pulse(0, 60);
		settle();
	endtask

	task automatic test_midphase_writes();
		write_reg(REG_HOLDOFF_TICKS, '1);
		run_echo_pulse(0, 5);
		repeat (40) send_tick(1'($urandom_range(0, 1)));
		settle();
		// holdoff count already past the new value
		write_reg(REG_HOLDOFF_TICKS, CFG_DATA_W'(7));
		write_reg(REG_TRIGGER_TICKS, CFG_DATA_W'(255));
		repeat (13) send_tick(1'($urandom_range(0, 1)));
		settle();
		write_reg(REG_TRIGGER_TICKS, CFG_DATA_W'(3));
		run_echo_pulse(0, 120);
		settle();
	endtask

	task automatic test_random_ranging();
		int unsigned first_tick;
		int unsigned first_reading;
		int unsigned val;
		int unsigned len;
		first_tick = ticks_sent;
		first_reading = readings_seen;
		while (ticks_sent - first_tick < 1000 || readings_seen - first_reading < 6) begin
			settle();
			tx_bursty = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0:       val = 0;
				1:       val = 255;
				2:       val = 1;
				default: val = $urandom_range(1, 12);
			endcase
			write_reg(REG_TRIGGER_TICKS, {12'($urandom), 8'(val)});
			case ($urandom_range(0, 5))
				0:       val = 0;
				1:       val = 1;
				default: val = $urandom_range(0, 40);
			endcase
			write_reg(REG_HOLDOFF_TICKS, HOLD_W'(val));
			case ($urandom_range(0, 7))
				0:       val = 0;
				1:       val = 1;
				2:       val = 1114;
				3:       val = 2047;
				default: val = $urandom_range(1, 60);
			endcase
			write_reg(REG_MAX_DISTANCE_CM, {9'($urandom), 11'(val)});
			repeat (3) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 30)) send_tick(1'($urandom_range(0, 1)));
				end else begin
					val = $urandom_range(0, 99);
					if (val < 80)
						len = $urandom_range(1, 120);
					else
						len = $urandom_range(120, 1300);
					run_echo_pulse($urandom_range(0, 6), len);
				end
			end
		end
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_edge_cases();
		test_midphase_writes();
		test_random_ranging();
		settle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
